// ===== hdl/assert_macros.svh =====
// Assertion macros shared by the tile scan conversion modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks that cond_a in a cycle implies cond_b in the same cycle.
`define ASSERT_IMPLIES(label, clk, rst_n, cond_a, cond_b) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond_a) |-> (cond_b)) \
		else $error("implication check failed");

// Checks that cond_a in a cycle implies cond_b in the next cycle.
`define ASSERT_NEXT(label, clk, rst_n, cond_a, cond_b) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond_a) |=> (cond_b)) \
		else $error("next cycle check failed");

`endif

// ===== hdl/rts_pkg.sv =====
// Shared constants and types of the raster to tile scan converter.
package rts_pkg;

	localparam int unsigned MAX_TILE_COLS_DEF     = 8;
	localparam int unsigned MAX_TILE_ROWS_DEF     = 8;
	localparam int unsigned MAX_PIC_CTBS_SIDE_DEF = 256;

	localparam int unsigned ADDR_W = 16;

	typedef enum logic [2:0] {
		CFG_PIC_WIDTH   = 3'd0,
		CFG_PIC_HEIGHT  = 3'd1,
		CFG_TILE_COLS   = 3'd2,
		CFG_TILE_ROWS   = 3'd3,
		CFG_UNIFORM     = 3'd4,
		CFG_COL_WIDTHS  = 3'd5,
		CFG_ROW_HEIGHTS = 3'd6
	} cfg_reg_t;

	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_OUTSIDE   = 2'd1;
	localparam logic [1:0] ST_BAD_SIZES = 2'd2;

	typedef struct packed {
		logic busy;
		logic sizes_bad;
	} bnd_status_t;

endpackage

// ===== hdl/rts_bound_gen.sv =====
// Sequencer that rebuilds the tile bounds and the width reciprocal from the registers.
`include "assert_macros.svh"
module rts_bound_gen #(
	parameter int unsigned MAX_TILE_COLS     = rts_pkg::MAX_TILE_COLS_DEF,
	parameter int unsigned MAX_TILE_ROWS     = rts_pkg::MAX_TILE_ROWS_DEF,
	parameter int unsigned MAX_PIC_CTBS_SIDE = rts_pkg::MAX_PIC_CTBS_SIDE_DEF,
	localparam int unsigned SW = $clog2(MAX_PIC_CTBS_SIDE + 1),
	localparam int unsigned CW = $clog2(MAX_TILE_COLS + 1),
	localparam int unsigned RW = $clog2(MAX_TILE_ROWS + 1)
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic [SW-1:0]         eff_width,
	input  logic [SW-1:0]         eff_height,
	input  logic [CW-1:0]         eff_cols,
	input  logic [RW-1:0]         eff_rows,
	input  logic                  uniform,
	input  logic [63:0]           col_m1,
	input  logic [63:0]           row_m1,
	output logic [SW-1:0]         col_bd [MAX_TILE_COLS+1],
	output logic [SW-1:0]         row_bd [MAX_TILE_ROWS+1],
	output logic [rts_pkg::ADDR_W:0] recip,
	output rts_pkg::bnd_status_t  status
);
	import rts_pkg::*;

	localparam int unsigned MT  = (MAX_TILE_COLS > MAX_TILE_ROWS) ? MAX_TILE_COLS : MAX_TILE_ROWS;
	localparam int unsigned KW  = $clog2(MT + 1);
	localparam int unsigned VW  = (SW > KW) ? SW : KW;
	localparam int unsigned PW  = $clog2(MT * MAX_PIC_CTBS_SIDE + 1);
	localparam int unsigned RCW = ADDR_W + 1;
	localparam int unsigned DW  = (PW > RCW) ? PW : RCW;
	localparam int unsigned AW  = $clog2(MT * 256 + 1);
	localparam int unsigned NW  = $clog2(DW + 1);

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_LOAD = 3'b010,
		ST_DIV  = 3'b100
	} state_t;

	typedef enum logic [1:0] {
		JOB_COL   = 2'd0,
		JOB_ROW   = 2'd1,
		JOB_RECIP = 2'd2
	} job_t;

	state_t        state_q;
	job_t          job_q;
	logic [KW-1:0] k_q;
	logic [AW-1:0] acc_q;
	logic          bad_q;
	logic [VW-1:0] rem_q;
	logic [VW-1:0] dvs_q;
	logic [DW-1:0] quo_q;
	logic [NW-1:0] cnt_q;
	logic [RCW-1:0] recip_q;
	logic [SW-1:0] col_q [MAX_TILE_COLS+1];
	logic [SW-1:0] row_q [MAX_TILE_ROWS+1];

	logic [KW-1:0] n_cur;
	logic [SW-1:0] size_cur;
	logic [63:0]   packed_cur;
	logic [7:0]    m1;
	logic [AW-1:0] acc_nx;
	logic [SW-1:0] expl_bd;
	logic          last;
	logic [VW:0]   rem_sh;
	logic          q_bit;
	logic [VW:0]   rem_diff;
	logic [DW-1:0] quo_nx;
	logic [DW-1:0] div_dend;
	logic [VW-1:0] div_dvs;
	logic [SW-1:0] bd_val;
	logic          wr_bd;
	logic          div_end;

	always_comb begin
		n_cur      = (job_q == JOB_ROW) ? KW'(eff_rows) : KW'(eff_cols);
		size_cur   = (job_q == JOB_ROW) ? eff_height : eff_width;
		packed_cur = (job_q == JOB_ROW) ? row_m1 : col_m1;
		m1 = '0;
		for (int j = 0; j < 8; j++) begin
			if ((j + 1 <= int'(MT)) && (k_q == KW'(j + 1))) begin
				m1 = packed_cur[8*j +: 8];
			end
		end
		acc_nx  = acc_q + AW'(m1) + AW'(1);
		expl_bd = (int'(acc_nx) > int'(size_cur)) ? size_cur : SW'(acc_nx);
		last    = (job_q == JOB_RECIP) || (k_q == n_cur);

		rem_sh   = {rem_q, quo_q[DW-1]};
		q_bit    = (rem_sh >= {1'b0, dvs_q});
		rem_diff = q_bit ? (rem_sh - {1'b0, dvs_q}) : rem_sh;
		quo_nx   = {quo_q[DW-2:0], q_bit};

		div_dend = (job_q == JOB_RECIP) ? (DW'(1) << ADDR_W) : (DW'(k_q) * DW'(size_cur));
		div_dvs  = (job_q == JOB_RECIP) ? VW'(eff_width) : VW'(n_cur);

		div_end = (state_q == ST_DIV) && (cnt_q == NW'(1));
		if (state_q == ST_DIV) begin
			bd_val = SW'(quo_nx);
		end else if (k_q == n_cur) begin
			bd_val = size_cur;
		end else begin
			bd_val = expl_bd;
		end
		wr_bd = (job_q != JOB_RECIP) &&
			(div_end || ((state_q == ST_LOAD) && !uniform));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
			job_q   <= JOB_COL;
			k_q     <= KW'(1);
			acc_q   <= '0;
			bad_q   <= 1'b0;
			rem_q   <= '0;
			dvs_q   <= '0;
			quo_q   <= '0;
			cnt_q   <= '0;
		end else if (start) begin
			state_q <= ST_LOAD;
			job_q   <= JOB_COL;
			k_q     <= KW'(1);
			acc_q   <= '0;
			bad_q   <= 1'b0;
		end else begin
			case (state_q)
				ST_LOAD: begin
					if ((job_q == JOB_RECIP) || uniform) begin
						quo_q   <= div_dend;
						rem_q   <= '0;
						dvs_q   <= div_dvs;
						cnt_q   <= NW'(DW);
						state_q <= ST_DIV;
					end else begin
						acc_q <= acc_nx;
						if (last) begin
							bad_q <= bad_q | (int'(acc_q) >= int'(size_cur));
						end
					end
				end
				ST_DIV: begin
					quo_q <= quo_nx;
					rem_q <= VW'(rem_diff);
					cnt_q <= cnt_q - NW'(1);
				end
				ST_IDLE: begin
				end
				default: state_q <= ST_IDLE;
			endcase

			// Once the current bound or the reciprocal is written, move on to the next bound or job, or go idle.
			if (div_end || ((state_q == ST_LOAD) && !uniform && (job_q != JOB_RECIP))) begin
				if (job_q == JOB_RECIP) begin
					state_q <= ST_IDLE;
				end else if (last && (job_q == JOB_COL)) begin
					job_q   <= JOB_ROW;
					k_q     <= KW'(1);
					acc_q   <= '0;
					state_q <= ST_LOAD;
				end else if (last) begin
					job_q   <= JOB_RECIP;
					state_q <= ST_LOAD;
				end else begin
					k_q     <= k_q + KW'(1);
					state_q <= ST_LOAD;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (div_end && (job_q == JOB_RECIP)) begin
			recip_q <= quo_nx[RCW-1:0];
		end
		for (int i = 1; i <= int'(MAX_TILE_COLS); i++) begin
			if (wr_bd && (job_q == JOB_COL) && (k_q == KW'(i))) begin
				col_q[i] <= bd_val;
			end
		end
		for (int i = 1; i <= int'(MAX_TILE_ROWS); i++) begin
			if (wr_bd && (job_q == JOB_ROW) && (k_q == KW'(i))) begin
				row_q[i] <= bd_val;
			end
		end
	end

	always_comb begin
		for (int i = 0; i <= int'(MAX_TILE_COLS); i++) begin
			col_bd[i] = (i == 0) ? '0 : col_q[i];
		end
		for (int i = 0; i <= int'(MAX_TILE_ROWS); i++) begin
			row_bd[i] = (i == 0) ? '0 : row_q[i];
		end
	end

	assign recip            = recip_q;
	assign status.busy      = (state_q != ST_IDLE);
	assign status.sizes_bad = bad_q;

	`ASSERT_IMPLIES(a_div_nonzero, clk, arst_n, state_q == ST_DIV, dvs_q != '0)
	`ASSERT_IMPLIES(a_k_range, clk, arst_n, state_q == ST_LOAD && job_q != JOB_RECIP, k_q != '0 && k_q <= n_cur)
	`ASSERT_NEXT(a_start_busy, clk, arst_n, start, status.busy)

endmodule

// ===== hdl/rts_addr_pipe.sv =====
// Seven-stage address pipeline: row split, tile search and tile scan sum.
`include "assert_macros.svh"
module rts_addr_pipe #(
	parameter int unsigned MAX_TILE_COLS     = rts_pkg::MAX_TILE_COLS_DEF,
	parameter int unsigned MAX_TILE_ROWS     = rts_pkg::MAX_TILE_ROWS_DEF,
	parameter int unsigned MAX_PIC_CTBS_SIDE = rts_pkg::MAX_PIC_CTBS_SIDE_DEF,
	localparam int unsigned SW = $clog2(MAX_PIC_CTBS_SIDE + 1),
	localparam int unsigned CW = $clog2(MAX_TILE_COLS + 1),
	localparam int unsigned RW = $clog2(MAX_TILE_ROWS + 1)
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  raster_valid,
	output logic                  raster_stall,
	input  logic [15:0]           raster_address,
	output logic                  result_valid,
	input  logic                  result_stall,
	output logic [15:0]           tile_scan_address,
	output logic [5:0]            tile_index,
	output logic [2:0]            tile_col_index,
	output logic [2:0]            tile_row_index,
	output logic [1:0]            status,
	input  logic [SW-1:0]         eff_width,
	input  logic [SW-1:0]         eff_height,
	input  logic [CW-1:0]         eff_cols,
	input  logic [RW-1:0]         eff_rows,
	input  logic [SW-1:0]         col_bd [MAX_TILE_COLS+1],
	input  logic [SW-1:0]         row_bd [MAX_TILE_ROWS+1],
	input  logic [rts_pkg::ADDR_W:0] recip,
	input  rts_pkg::bnd_status_t  bnd
);
	import rts_pkg::*;

	localparam int unsigned XW = SW + 1;
	localparam int unsigned MW = 2 * SW;
	localparam int unsigned TW = 2 * SW + 2;

	logic en;
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7;

	logic [ADDR_W-1:0] addr_s1, addr_s2;
	logic [ADDR_W-1:0] y0_s2, y0_s3;
	logic              oob_s2, oob_s3, oob_s4, oob_s5, oob_s6;
	logic [XW-1:0]     x0_s3;
	logic [SW-1:0]     x_s4, y_s4, x_s5, y_s5;
	logic [CW-1:0]     tx_s5;
	logic [RW-1:0]     ty_s5;
	logic [SW-1:0]     cs0_s5, cs1_s5, rs0_s5, rs1_s5;
	logic [MW-1:0]     t1_s6, t2_s6, t3_s6;
	logic [SW-1:0]     t4_s6;
	logic [5:0]        tidx_s6;
	logic [2:0]        tx_s6, ty_s6;

	logic [2*ADDR_W:0] prod;
	logic [MW-1:0]     area;
	logic [CW-1:0]     tx_c;
	logic [RW-1:0]     ty_c;
	logic [SW-1:0]     cs0_c, cs1_c, rs0_c, rs1_c;
	logic [TW-1:0]     ts_sum;

	// The whole pipe moves together; it holds only when a result waits.
	assign en           = !(v_s7 && result_stall);
	assign raster_stall = !en || bnd.busy;
	assign result_valid = v_s7;

	assign prod = (2*ADDR_W+1)'(addr_s1) * (2*ADDR_W+1)'(recip);
	assign area = MW'(eff_width) * MW'(eff_height);

	// Bounds never decrease, so the last start not beyond the block wins.
	always_comb begin
		tx_c  = '0;
		cs0_c = col_bd[0];
		cs1_c = col_bd[1];
		for (int i = 0; i < int'(MAX_TILE_COLS); i++) begin
			if ((i < int'(eff_cols)) && (x_s4 >= col_bd[i])) begin
				tx_c  = CW'(i);
				cs0_c = col_bd[i];
				cs1_c = col_bd[i+1];
			end
		end
		ty_c  = '0;
		rs0_c = row_bd[0];
		rs1_c = row_bd[1];
		for (int i = 0; i < int'(MAX_TILE_ROWS); i++) begin
			if ((i < int'(eff_rows)) && (y_s4 >= row_bd[i])) begin
				ty_c  = RW'(i);
				rs0_c = row_bd[i];
				rs1_c = row_bd[i+1];
			end
		end
	end

	assign ts_sum = TW'(t1_s6) + TW'(t2_s6) + TW'(t3_s6) + TW'(t4_s6);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
		end else if (en) begin
			v_s1 <= raster_valid && !bnd.busy;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			addr_s1 <= raster_address;

			addr_s2 <= addr_s1;
			y0_s2   <= prod[ADDR_W +: ADDR_W];
			oob_s2  <= (int'(addr_s1) >= int'(area));

			// The reciprocal rounds down, so the row is exact or one short.
			x0_s3  <= XW'(addr_s2 - ADDR_W'(y0_s2 * ADDR_W'(eff_width)));
			y0_s3  <= y0_s2;
			oob_s3 <= oob_s2;

			if (x0_s3 >= XW'(eff_width)) begin
				x_s4 <= SW'(x0_s3 - XW'(eff_width));
				y_s4 <= SW'(y0_s3 + ADDR_W'(1));
			end else begin
				x_s4 <= SW'(x0_s3);
				y_s4 <= SW'(y0_s3);
			end
			oob_s4 <= oob_s3;

			x_s5   <= x_s4;
			y_s5   <= y_s4;
			tx_s5  <= tx_c;
			ty_s5  <= ty_c;
			cs0_s5 <= cs0_c;
			cs1_s5 <= cs1_c;
			rs0_s5 <= rs0_c;
			rs1_s5 <= rs1_c;
			oob_s5 <= oob_s4;

			t1_s6   <= MW'(eff_width) * MW'(rs0_s5);
			t2_s6   <= MW'(rs1_s5 - rs0_s5) * MW'(cs0_s5);
			t3_s6   <= MW'(y_s5 - rs0_s5) * MW'(cs1_s5 - cs0_s5);
			t4_s6   <= x_s5 - cs0_s5;
			tidx_s6 <= 6'(int'(ty_s5) * int'(eff_cols) + int'(tx_s5));
			tx_s6   <= 3'(tx_s5);
			ty_s6   <= 3'(ty_s5);
			oob_s6  <= oob_s5;

			if (bnd.sizes_bad || oob_s6) begin
				tile_scan_address <= '0;
				tile_index        <= '0;
				tile_col_index    <= '0;
				tile_row_index    <= '0;
				status            <= bnd.sizes_bad ? ST_BAD_SIZES : ST_OUTSIDE;
			end else begin
				tile_scan_address <= 16'(ts_sum);
				tile_index        <= tidx_s6;
				tile_col_index    <= tx_s6;
				tile_row_index    <= ty_s6;
				status            <= ST_OK;
			end
		end
	end

	`ASSERT_IMPLIES(a_busy_stalls, clk, arst_n, bnd.busy, raster_stall)
	`ASSERT_IMPLIES(a_fail_zero, clk, arst_n, result_valid && status != ST_OK, tile_scan_address == '0 && tile_index == '0)
	`ASSERT_IMPLIES(a_col_range, clk, arst_n, result_valid && status == ST_OK, int'(tile_col_index) < int'(eff_cols))

endmodule

// ===== hdl/ctb_raster_to_tile_scan.sv =====
// Top level: configuration registers, bound builder and address pipeline.
// An accepted raster address runs through the registered address pipeline to its result item.
// Throughput: one item per cycle while the result side does not stall and the bound builder is not busy.
// Reset loads a 1x1 picture with one tile, then the bound builder runs; it runs
// again after each register write and holds raster_stall while it is busy.
module ctb_raster_to_tile_scan #(
	parameter int unsigned MAX_TILE_COLS     = rts_pkg::MAX_TILE_COLS_DEF,
	parameter int unsigned MAX_TILE_ROWS     = rts_pkg::MAX_TILE_ROWS_DEF,
	parameter int unsigned MAX_PIC_CTBS_SIDE = rts_pkg::MAX_PIC_CTBS_SIDE_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [63:0] cfg_data,
	input  logic        raster_valid,
	output logic        raster_stall,
	input  logic [15:0] raster_address,
	output logic        result_valid,
	input  logic        result_stall,
	output logic [15:0] tile_scan_address,
	output logic [5:0]  tile_index,
	output logic [2:0]  tile_col_index,
	output logic [2:0]  tile_row_index,
	output logic [1:0]  status
);
	import rts_pkg::*;

	localparam int unsigned SW = $clog2(MAX_PIC_CTBS_SIDE + 1);
	localparam int unsigned CW = $clog2(MAX_TILE_COLS + 1);
	localparam int unsigned RW = $clog2(MAX_TILE_ROWS + 1);

	logic [8:0]  pic_width_q;
	logic [8:0]  pic_height_q;
	logic [3:0]  tile_cols_q;
	logic [3:0]  tile_rows_q;
	logic        uniform_q;
	logic [63:0] col_m1_q;
	logic [63:0] row_m1_q;

	logic          cfg_wr;
	logic [SW-1:0] eff_width, eff_height;
	logic [CW-1:0] eff_cols;
	logic [RW-1:0] eff_rows;
	logic [SW-1:0] col_bd [MAX_TILE_COLS+1];
	logic [SW-1:0] row_bd [MAX_TILE_ROWS+1];
	logic [ADDR_W:0] recip;
	bnd_status_t   bnd;

	assign cfg_ready = 1'b1;
	assign cfg_wr    = cfg_valid && cfg_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pic_width_q  <= 9'd1;
			pic_height_q <= 9'd1;
			tile_cols_q  <= 4'd1;
			tile_rows_q  <= 4'd1;
			uniform_q    <= 1'b1;
			col_m1_q     <= '0;
			row_m1_q     <= '0;
		end else if (cfg_wr) begin
			case (cfg_index)
				CFG_PIC_WIDTH:   pic_width_q  <= cfg_data[8:0];
				CFG_PIC_HEIGHT:  pic_height_q <= cfg_data[8:0];
				CFG_TILE_COLS:   tile_cols_q  <= cfg_data[3:0];
				CFG_TILE_ROWS:   tile_rows_q  <= cfg_data[3:0];
				CFG_UNIFORM:     uniform_q    <= cfg_data[0];
				CFG_COL_WIDTHS:  col_m1_q     <= cfg_data;
				CFG_ROW_HEIGHTS: row_m1_q     <= cfg_data;
				default: ;
			endcase
		end
	end

	// Zero or oversized sizes and counts saturate into their legal range.
	always_comb begin
		if (pic_width_q == '0) eff_width = SW'(1);
		else if (int'(pic_width_q) > int'(MAX_PIC_CTBS_SIDE)) eff_width = SW'(MAX_PIC_CTBS_SIDE);
		else eff_width = SW'(pic_width_q);
		if (pic_height_q == '0) eff_height = SW'(1);
		else if (int'(pic_height_q) > int'(MAX_PIC_CTBS_SIDE)) eff_height = SW'(MAX_PIC_CTBS_SIDE);
		else eff_height = SW'(pic_height_q);
		if (tile_cols_q == '0) eff_cols = CW'(1);
		else if (int'(tile_cols_q) > int'(MAX_TILE_COLS)) eff_cols = CW'(MAX_TILE_COLS);
		else eff_cols = CW'(tile_cols_q);
		if (tile_rows_q == '0) eff_rows = RW'(1);
		else if (int'(tile_rows_q) > int'(MAX_TILE_ROWS)) eff_rows = RW'(MAX_TILE_ROWS);
		else eff_rows = RW'(tile_rows_q);
	end

	rts_bound_gen #(
		.MAX_TILE_COLS     (MAX_TILE_COLS),
		.MAX_TILE_ROWS     (MAX_TILE_ROWS),
		.MAX_PIC_CTBS_SIDE (MAX_PIC_CTBS_SIDE)
	) u_bound_gen (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (cfg_wr),
		.eff_width  (eff_width),
		.eff_height (eff_height),
		.eff_cols   (eff_cols),
		.eff_rows   (eff_rows),
		.uniform    (uniform_q),
		.col_m1     (col_m1_q),
		.row_m1     (row_m1_q),
		.col_bd     (col_bd),
		.row_bd     (row_bd),
		.recip      (recip),
		.status     (bnd)
	);

	rts_addr_pipe #(
		.MAX_TILE_COLS     (MAX_TILE_COLS),
		.MAX_TILE_ROWS     (MAX_TILE_ROWS),
		.MAX_PIC_CTBS_SIDE (MAX_PIC_CTBS_SIDE)
	) u_addr_pipe (
		.clk               (clk),
		.arst_n            (arst_n),
		.raster_valid      (raster_valid),
		.raster_stall      (raster_stall),
		.raster_address    (raster_address),
		.result_valid      (result_valid),
		.result_stall      (result_stall),
		.tile_scan_address (tile_scan_address),
		.tile_index        (tile_index),
		.tile_col_index    (tile_col_index),
		.tile_row_index    (tile_row_index),
		.status            (status),
		.eff_width         (eff_width),
		.eff_height        (eff_height),
		.eff_cols          (eff_cols),
		.eff_rows          (eff_rows),
		.col_bd            (col_bd),
		.row_bd            (row_bd),
		.recip             (recip),
		.bnd               (bnd)
	);

endmodule
